// ----- hw/rtl/frcr_pkg.sv -----
package frcr_pkg;

  // Default frame store geometry
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;

  // Field widths
  localparam int unsigned DimW     = 9;
  localparam int unsigned DimMax   = (1 << DimW) - 1;
  localparam int unsigned PixW     = 24;
  localparam int unsigned BytesW   = 18;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CfgW     = 9;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;

  // Output row layout
  localparam int unsigned BytesPerPixel = 3;
  localparam int unsigned RowAlign      = 4;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegImageWidth   = 3'd0;
  localparam logic [IdxW-1:0] RegImageHeight  = 3'd1;
  localparam logic [IdxW-1:0] RegTransform    = 3'd2;
  localparam logic [IdxW-1:0] RegWindowTop    = 3'd3;
  localparam logic [IdxW-1:0] RegWindowLeft   = 3'd4;
  localparam logic [IdxW-1:0] RegWindowHeight = 3'd5;
  localparam logic [IdxW-1:0] RegWindowWidth  = 3'd6;

  // Request operation codes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpFetch = 1'b1;

  // Transform modes
  localparam logic ModeCrop   = 1'b0;
  localparam logic ModeRotate = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic fetch_take;
    logic calc_en;
    logic read_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] max_v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > max_v) begin
      r = max_v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/frcr_ctrl.sv -----
module frcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_op_i,
  output logic             req_ready_o,
  input  frcr_pkg::status_t status_i,
  output frcr_pkg::cmd_t    cmd_o
);
  import frcr_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCalc = 4'b0010,
    StRead = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   idle;

  assign idle        = (state_q == StIdle);
  assign req_ready_o = idle;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_wr    = idle && req_valid_i && (req_op_i == OpLoad);
    cmd_o.fetch_take = idle && req_valid_i && (req_op_i == OpFetch);
    cmd_o.calc_en    = (state_q == StCalc);
    cmd_o.read_en    = (state_q == StRead);
    cmd_o.out_load   = (state_q == StDone) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i && (req_op_i == OpFetch)) state_d = StCalc;
      end
      StCalc: state_d = StRead;
      StRead: state_d = StDone;
      StDone: begin
        // hold the pixel until the output register frees up
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/frcr_dp.sv -----
module frcr_dp #(
  parameter int unsigned MAX_WIDTH  = frcr_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = frcr_pkg::MaxHeightDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frcr_pkg::cmd_t               cmd_i,
  output frcr_pkg::status_t            status_o,
  input  logic [frcr_pkg::PixW-1:0]    pixel_i,
  input  logic                         cfg_valid_i,
  input  logic [frcr_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [frcr_pkg::CfgW-1:0]    cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [frcr_pkg::PixW-1:0]    out_pixel_o,
  output logic                         out_last_o,
  output logic [frcr_pkg::DimW-1:0]    out_width_o,
  output logic [frcr_pkg::DimW-1:0]    out_height_o,
  output logic [frcr_pkg::BytesW-1:0]  out_bytes_o,
  output logic                         out_error_o
);
  import frcr_pkg::*;

  localparam int unsigned CapW   = (MAX_WIDTH > DimMax) ? DimMax : MAX_WIDTH;
  localparam int unsigned CapH   = (MAX_HEIGHT > DimMax) ? DimMax : MAX_HEIGHT;
  localparam int unsigned CapDim = (CapW > CapH) ? CapW : CapH;
  localparam int unsigned CntW   = $clog2(CapDim);
  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned AreaW  = 2 * DimW;
  localparam int unsigned CmpW   = ((AddrW > AreaW) ? AddrW : AreaW) + 1;
  localparam int unsigned RbW    = DimW + 3;
  localparam int unsigned BfW    = DimW + RbW;

  // configuration registers
  logic [DimW-1:0] img_w_q, img_h_q, win_h_q, win_w_q;
  logic            mode_q;
  logic [7:0]      win_top_q, win_left_q;

  // sequencing state
  logic [AddrW-1:0] load_q;
  logic [CntW-1:0]  emit_row_q, emit_col_q;

  // fetch pipeline
  logic [DimW-1:0]   srow_q, scol_q, ow_q, oh_q;
  logic              err_q, last_q;
  logic [AddrW-1:0]  addr_q;
  logic [BytesW-1:0] bytes_q;
  logic [PixW-1:0]   rdata_q;

  // output register
  logic              out_valid_q;
  logic [PixW-1:0]   out_pixel_q;
  logic              out_last_q, out_error_q;
  logic [DimW-1:0]   out_width_q, out_height_q;
  logic [BytesW-1:0] out_bytes_q;

  logic [PixW-1:0] frame_mem [Depth];

  logic [DimW-1:0]  iw, ih, ww, wh;
  logic [AreaW-1:0] area;
  logic [CmpW-1:0]  load_inc;
  logic             load_wrap;
  logic             cfg_hit, dims_hit;
  logic [DimW-1:0]  row_ext, col_ext;
  logic [DimW-1:0]  ow, oh, srow, scol;
  logic             err, last_col, last_row;
  logic [AreaW-1:0] prod, addr_sum;
  logic [RbW-1:0]   row_raw, row_bytes;
  logic [BfW-1:0]   bytes_full;

  assign iw = clamp_dim(img_w_q, DimW'(CapW));
  assign ih = clamp_dim(img_h_q, DimW'(CapH));
  assign ww = clamp_dim(win_w_q, DimW'(CapW));
  assign wh = clamp_dim(win_h_q, DimW'(CapH));

  assign area      = AreaW'(iw) * AreaW'(ih);
  assign load_inc  = CmpW'(load_q) + CmpW'(1);
  assign load_wrap = (load_inc >= CmpW'(area));

  assign cfg_hit  = cfg_valid_i && (cfg_index_i <= RegWindowWidth);
  assign dims_hit = cfg_valid_i &&
                    ((cfg_index_i == RegImageWidth) || (cfg_index_i == RegImageHeight));

  assign row_ext = DimW'(emit_row_q);
  assign col_ext = DimW'(emit_col_q);

  always_comb begin
    if (mode_q == ModeRotate) begin
      ow   = ih;
      oh   = iw;
      srow = col_ext;
      scol = iw - DimW'(1) - row_ext;
      err  = 1'b0;
    end else begin
      ow   = ww;
      oh   = wh;
      srow = ih - DimW'(win_top_q) - wh + row_ext;
      scol = DimW'(win_left_q) + col_ext;
      err  = ((DimW + 1)'(win_top_q) + (DimW + 1)'(wh) > (DimW + 1)'(ih)) ||
             ((DimW + 1)'(win_left_q) + (DimW + 1)'(ww) > (DimW + 1)'(iw));
    end
  end

  assign last_col = (col_ext == ow - DimW'(1));
  assign last_row = (row_ext == oh - DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= DimW'(1);
      img_h_q    <= DimW'(1);
      mode_q     <= ModeCrop;
      win_top_q  <= '0;
      win_left_q <= '0;
      win_h_q    <= DimW'(1);
      win_w_q    <= DimW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegImageWidth:   img_w_q    <= cfg_data_i;
        RegImageHeight:  img_h_q    <= cfg_data_i;
        RegTransform:    mode_q     <= cfg_data_i[0];
        RegWindowTop:    win_top_q  <= cfg_data_i[7:0];
        RegWindowLeft:   win_left_q <= cfg_data_i[7:0];
        RegWindowHeight: win_h_q    <= cfg_data_i;
        RegWindowWidth:  win_w_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q     <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
    end else begin
      if (dims_hit) begin
        load_q <= '0;
      end else if (cmd_i.load_wr) begin
        load_q <= load_wrap ? '0 : AddrW'(load_inc);
      end
      if (cfg_hit) begin
        emit_row_q <= '0;
        emit_col_q <= '0;
      end else if (cmd_i.fetch_take) begin
        // advance in output raster order, wrap after the last pixel
        if (last_col && last_row) begin
          emit_row_q <= '0;
          emit_col_q <= '0;
        end else if (last_col) begin
          emit_row_q <= emit_row_q + CntW'(1);
          emit_col_q <= '0;
        end else begin
          emit_col_q <= emit_col_q + CntW'(1);
        end
      end
    end
  end

  // latch the geometry of the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_take) begin
      srow_q <= srow;
      scol_q <= scol;
      ow_q   <= ow;
      oh_q   <= oh;
      err_q  <= err;
      last_q <= last_col && last_row;
    end
  end

  assign prod       = AreaW'(srow_q) * AreaW'(iw);
  assign addr_sum   = prod + AreaW'(scol_q);
  assign row_raw    = RbW'(ow_q) * RbW'(BytesPerPixel);
  assign row_bytes  = (row_raw + RbW'(RowAlign - 1)) & ~RbW'(RowAlign - 1);
  assign bytes_full = BfW'(oh_q) * BfW'(row_bytes);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      addr_q  <= AddrW'(addr_sum);
      bytes_q <= BytesW'(bytes_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      frame_mem[load_q] <= pixel_i;
    end
    if (cmd_i.read_en) begin
      rdata_q <= frame_mem[addr_q];
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      // drop the pixel of a window that runs outside the image
      out_pixel_q  <= err_q ? '0 : rdata_q;
      out_last_q   <= last_q;
      out_width_q  <= ow_q;
      out_height_q <= oh_q;
      out_bytes_q  <= bytes_q;
      out_error_q  <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign out_last_o   = out_last_q;
  assign out_width_o  = out_width_q;
  assign out_height_o = out_height_q;
  assign out_bytes_o  = out_bytes_q;
  assign out_error_o  = out_error_q;

endmodule

// ----- hw/rtl/frame_crop_rotate_engine_unit.sv -----
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel_in; tuser: operation
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: pixel/size; tlast; tuser: error
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// A load request writes the frame store at the load pointer.
// A fetch request runs these steps in order: latch geometry, address and byte-count
// multiply, frame store read, output register load.
// The output register parts the sides: loads go on while a result waits.
// Reset clears the controller, counters and configuration; the frame store
// holds no reset and needs no clearing pass.
module frame_crop_rotate_engine_unit #(
  parameter int unsigned MAX_WIDTH  = frcr_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = frcr_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [frcr_pkg::InDataW-1:0]   s_axis_tdata,   // [23:0] pixel_in
  input  logic                           s_axis_tuser,   // [0] operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [23:0] pixel_out, [32:24] out_width, [41:33] out_height, [59:42] image_bytes
  output logic [frcr_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser,   // [0] window_error
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [frcr_pkg::IdxW-1:0]      cfg_index_i,
  input  logic [frcr_pkg::CfgW-1:0]      cfg_data_i
);
  import frcr_pkg::*;

  localparam int unsigned PadW = OutDataW - PixW - 2 * DimW - BytesW;

  cmd_t              cmd;
  status_t           status;
  logic [PixW-1:0]   out_pixel;
  logic [DimW-1:0]   out_width, out_height;
  logic [BytesW-1:0] out_bytes;

  assign cfg_ready_o = 1'b1;

  frcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_op_i    (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  frcr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .pixel_i      (s_axis_tdata[PixW-1:0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pixel_o  (out_pixel),
    .out_last_o   (m_axis_tlast),
    .out_width_o  (out_width),
    .out_height_o (out_height),
    .out_bytes_o  (out_bytes),
    .out_error_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, out_bytes, out_height, out_width, out_pixel};

endmodule
